>>> sv/atlas_slot_allocator_unit_defines.svh
// Assertion macros used by the slot allocator unit RTL file.
// No dependencies; the macros become empty when SYNTHESIS is defined.
`ifndef ATLAS_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define ATLAS_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while the active-low reset is asserted.
`define ASU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("slot allocator assertion failed");
// Checked property that is also evaluated during reset.
`define ASU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("slot allocator assertion failed");
`else
`define ASU_ASSERT(lbl, clk, rstn, prop)
`define ASU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/asu_pkg.sv
// Package for the atlas slot allocator: default geometry, request and status codes.
// No dependencies.
package asu_pkg;

  localparam int unsigned ATLAS_WIDTH = 16;
  localparam int unsigned MAX_PAGES   = 4;

  typedef enum logic [1:0] {
    FN_SINGLE = 2'd0,
    FN_RUN    = 2'd1,
    FN_BOX    = 2'd2,
    FN_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

endpackage

>>> sv/asu_req_if.sv
// Request channel of the atlas slot allocator: valid/ready and the request fields.
// No dependencies.
interface asu_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [8:0] run_length;
  logic [4:0] box_width;
  logic [4:0] box_height;

  modport source (output valid, func, run_length, box_width, box_height, input ready);
  modport sink (input valid, func, run_length, box_width, box_height, output ready);
endinterface

>>> sv/asu_rsp_if.sv
// Response channel of the atlas slot allocator: valid/ready, slot index and status.
// No dependencies.
interface asu_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] slot_index;
  logic [1:0] status;

  modport source (output valid, slot_index, status, input ready);
  modport sink (input valid, slot_index, status, output ready);
endinterface

>>> sv/asu_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module asu_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/atlas_slot_allocator_unit.sv
// Atlas slot allocator. A single request reads slots from the hint until it finds a free one;
// a run reads until it has n free slots in a row, then marks them; a box splits the hint, tries
// positions, tests each slot of one and marks its w*h slots. Full, rejected or empty requests end early.
// The unit handles one request at a time; the next transfer is taken once the result is loaded,
// and a held result stalls the unit. After reset and after a clear the bitmap is swept, one
// slot per cycle across all ATLAS_WIDTH*ATLAS_WIDTH*MAX_PAGES slots, and no request is taken.
`include "atlas_slot_allocator_unit_defines.svh"

module atlas_slot_allocator_unit #(
  parameter int unsigned ATLAS_WIDTH = asu_pkg::ATLAS_WIDTH,
  parameter int unsigned MAX_PAGES   = asu_pkg::MAX_PAGES
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  asu_req_if.sink   req_i,
  asu_rsp_if.source rsp_o
);

  // Geometry. The scan position is wide enough to reach past the last slot and to
  // hold any search hint.
  localparam int unsigned SPP   = ATLAS_WIDTH * ATLAS_WIDTH;
  localparam int unsigned TOTAL = SPP * MAX_PAGES;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned SW    = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int unsigned XW    = $clog2(ATLAS_WIDTH + 1);
  localparam int unsigned CW    = 8;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_LRD   = 11'b000_0000_0100,
    ST_LWT   = 11'b000_0000_1000,
    ST_DECP  = 11'b000_0001_0000,
    ST_DECR  = 11'b000_0010_0000,
    ST_BPOS  = 11'b000_0100_0000,
    ST_BRD   = 11'b000_1000_0000,
    ST_BWT   = 11'b001_0000_0000,
    ST_MARK  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Request and search state.
  logic [10:0]   hint_q, hint_d;
  logic          resp_q, resp_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    func_q, func_d;
  logic [8:0]    n_q, n_d;
  logic [4:0]    bw_q, bw_d;
  logic [4:0]    bh_q, bh_d;
  logic [SW-1:0] s_q, s_d;
  logic [8:0]    cnt_q, cnt_d;
  logic          skip_q, skip_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] pb_q, pb_d;
  logic [XW-1:0] x_q, x_d;
  logic [XW-1:0] y_q, y_d;

  // Rectangle walker, shared by the box test and the marking sweep.
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] rowb_q, rowb_d;
  logic [8:0]    cc_q, cc_d;
  logic [XW-1:0] rr_q, rr_d;
  logic [8:0]    cw_q, cw_d;
  logic [XW-1:0] ch_q, ch_d;

  // Result waiting to be loaded, and the output register.
  logic [SW-1:0] res_idx_q, res_idx_d;
  logic [1:0]    res_st_q, res_st_d;
  logic          out_valid_q, out_valid_d;
  logic [9:0]    out_idx_q, out_idx_d;
  logic [1:0]    out_st_q, out_st_d;

  // Bitmap RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic          ram_wdata;
  logic          ram_rdata;

  logic          last_col;
  logic          last_row;
  logic [SW-1:0] run_base;
  logic          s_past_end;

  asu_ram #(
    .WIDTH (1),
    .DEPTH (TOTAL)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign last_col   = (cc_q == cw_q - 9'd1);
  assign last_row   = (rr_q == ch_q - XW'(1));
  assign run_base   = s_q + SW'(1) - SW'(n_q);
  assign s_past_end = (s_q >= SW'(TOTAL));

  always_comb begin
    state_d     = state_q;
    hint_d      = hint_q;
    resp_d      = resp_q;
    clr_d       = clr_q;
    func_d      = func_q;
    n_d         = n_q;
    bw_d        = bw_q;
    bh_d        = bh_q;
    s_d         = s_q;
    cnt_d       = cnt_q;
    skip_d      = skip_q;
    rem_d       = rem_q;
    pb_d        = pb_q;
    x_d         = x_q;
    y_d         = y_q;
    addr_d      = addr_q;
    rowb_d      = rowb_q;
    cc_d        = cc_q;
    rr_d        = rr_q;
    cw_d        = cw_q;
    ch_d        = ch_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    ram_we      = 1'b0;
    ram_addr    = s_q[AW-1:0];
    ram_wdata   = 1'b1;
    req_i.ready = 1'b0;

    // The response register empties on its own transfer.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Slot 0 stays reserved; every other slot becomes free.
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = (clr_q == '0);
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(TOTAL - 1)) begin
          state_d = resp_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          func_d    = req_i.func;
          n_d       = req_i.run_length;
          bw_d      = req_i.box_width;
          bh_d      = req_i.box_height;
          s_d       = SW'(hint_q);
          cnt_d     = '0;
          skip_d    = 1'b0;
          res_idx_d = '0;
          res_st_d  = asu_pkg::STAT_OK;
          unique case (req_i.func)
            asu_pkg::FN_SINGLE: begin
              state_d = ST_LRD;
            end
            asu_pkg::FN_RUN: begin
              // An empty run allocates nothing.
              state_d = (req_i.run_length == '0) ? ST_DONE : ST_LRD;
            end
            asu_pkg::FN_BOX: begin
              if (req_i.box_width == '0 || req_i.box_height == '0 ||
                  CW'(req_i.box_width) > CW'(ATLAS_WIDTH) ||
                  CW'(req_i.box_height) > CW'(ATLAS_WIDTH)) begin
                res_st_d = asu_pkg::STAT_TOO_LARGE;
                state_d  = ST_DONE;
              end else begin
                rem_d   = SW'(hint_q);
                pb_d    = '0;
                y_d     = '0;
                state_d = ST_DECP;
              end
            end
            default: begin
              hint_d  = 11'd1;
              resp_d  = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
          endcase
        end
      end

      ST_LRD: begin
        if (s_past_end) begin
          res_idx_d = '0;
          res_st_d  = asu_pkg::STAT_FULL;
          state_d   = ST_DONE;
        end else begin
          state_d = ST_LWT;
        end
      end

      ST_LWT: begin
        if (func_q == asu_pkg::FN_SINGLE) begin
          if (!ram_rdata) begin
            ram_we    = 1'b1;
            hint_d    = 11'(s_q + SW'(1));
            res_idx_d = s_q;
            state_d   = ST_DONE;
          end else begin
            s_d     = s_q + SW'(1);
            state_d = ST_LRD;
          end
        end else if (ram_rdata) begin
          if (cnt_q != '0) begin
            skip_d = 1'b1;
          end
          cnt_d   = '0;
          s_d     = s_q + SW'(1);
          state_d = ST_LRD;
        end else if (cnt_q + 9'd1 == n_q) begin
          // Run complete: mark it as a one-row rectangle starting at its base.
          if (!skip_q) begin
            hint_d = 11'(s_q + SW'(1));
          end
          res_idx_d = run_base;
          addr_d    = run_base[AW-1:0];
          rowb_d    = run_base[AW-1:0];
          cc_d      = '0;
          rr_d      = '0;
          cw_d      = n_q;
          ch_d      = XW'(1);
          state_d   = ST_MARK;
        end else begin
          cnt_d   = cnt_q + 9'd1;
          s_d     = s_q + SW'(1);
          state_d = ST_LRD;
        end
      end

      ST_DECP: begin
        // Split the hint into page base, row and column by repeated subtraction.
        if (rem_q >= SW'(SPP)) begin
          rem_d = rem_q - SW'(SPP);
          pb_d  = pb_q + SW'(SPP);
        end else begin
          state_d = ST_DECR;
        end
      end

      ST_DECR: begin
        if (rem_q >= SW'(ATLAS_WIDTH)) begin
          rem_d = rem_q - SW'(ATLAS_WIDTH);
          y_d   = y_q + XW'(1);
        end else begin
          x_d     = rem_q[XW-1:0];
          state_d = ST_BPOS;
        end
      end

      ST_BPOS: begin
        if (s_past_end) begin
          res_idx_d = '0;
          res_st_d  = asu_pkg::STAT_FULL;
          state_d   = ST_DONE;
        end else if (CW'(y_q) + CW'(bh_q) > CW'(ATLAS_WIDTH)) begin
          s_d  = pb_q + SW'(SPP);
          pb_d = pb_q + SW'(SPP);
          x_d  = '0;
          y_d  = '0;
        end else if (CW'(x_q) + CW'(bw_q) > CW'(ATLAS_WIDTH)) begin
          s_d = s_q + SW'(ATLAS_WIDTH) - SW'(x_q);
          x_d = '0;
          y_d = y_q + XW'(1);
        end else begin
          addr_d  = s_q[AW-1:0];
          rowb_d  = s_q[AW-1:0];
          cc_d    = '0;
          rr_d    = '0;
          cw_d    = 9'(bw_q);
          ch_d    = XW'(bh_q);
          state_d = ST_BRD;
        end
      end

      ST_BRD: begin
        ram_addr = addr_q;
        state_d  = ST_BWT;
      end

      ST_BWT: begin
        if (ram_rdata) begin
          s_d     = s_q + SW'(1);
          x_d     = x_q + XW'(1);
          state_d = ST_BPOS;
        end else if (last_col && last_row) begin
          res_idx_d = s_q;
          addr_d    = s_q[AW-1:0];
          rowb_d    = s_q[AW-1:0];
          cc_d      = '0;
          rr_d      = '0;
          state_d   = ST_MARK;
        end else if (last_col) begin
          rr_d    = rr_q + XW'(1);
          rowb_d  = rowb_q + AW'(ATLAS_WIDTH);
          addr_d  = rowb_q + AW'(ATLAS_WIDTH);
          cc_d    = '0;
          state_d = ST_BRD;
        end else begin
          cc_d    = cc_q + 9'd1;
          addr_d  = addr_q + AW'(1);
          state_d = ST_BRD;
        end
      end

      ST_MARK: begin
        ram_we   = 1'b1;
        ram_addr = addr_q;
        if (last_col && last_row) begin
          state_d = ST_DONE;
        end else if (last_col) begin
          rr_d   = rr_q + XW'(1);
          rowb_d = rowb_q + AW'(ATLAS_WIDTH);
          addr_d = rowb_q + AW'(ATLAS_WIDTH);
          cc_d   = '0;
        end else begin
          cc_d   = cc_q + 9'd1;
          addr_d = addr_q + AW'(1);
        end
      end

      ST_DONE: begin
        // Load the result once the output register is free or being emptied.
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q[9:0];
          out_st_d    = res_st_q;
          resp_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hint_q      <= 11'd1;
      resp_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      resp_q      <= resp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    n_q       <= n_d;
    bw_q      <= bw_d;
    bh_q      <= bh_d;
    s_q       <= s_d;
    cnt_q     <= cnt_d;
    skip_q    <= skip_d;
    rem_q     <= rem_d;
    pb_q      <= pb_d;
    x_q       <= x_d;
    y_q       <= y_d;
    addr_q    <= addr_d;
    rowb_q    <= rowb_d;
    cc_q      <= cc_d;
    rr_q      <= rr_d;
    cw_q      <= cw_d;
    ch_q      <= ch_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_st_q  <= out_st_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.slot_index = out_idx_q;
  assign rsp_o.status     = out_st_q;

  // The bitmap is written only by the clearing sweep, a single grant or a marking sweep.
  `ASU_ASSERT(a_write_states, clk_i, rst_ni, ram_we |-> (state_q == ST_CLEAR || state_q == ST_LWT || state_q == ST_MARK))
  // Marking never leaves the bitmap.
  `ASU_ASSERT(a_mark_in_range, clk_i, rst_ni, (state_q == ST_MARK) |-> (32'(addr_q) < TOTAL))
  // A full or oversize result carries index zero.
  `ASU_ASSERT(a_fail_index, clk_i, rst_ni, (out_valid_q && out_st_q != asu_pkg::STAT_OK) |-> (out_idx_q == '0))
  // Requests are never taken while the clearing sweep runs.
  `ASU_ASSERT_ALWAYS(a_no_req_in_clear, clk_i, (state_q == ST_CLEAR) |-> !req_i.ready)

endmodule
